// ===== rtl/edett_pkg.sv =====
// Package for the earliest-deadline event timer table.
// Holds the item types, the slot record, the edit command, op and status codes and sizes.
// Used by every module of the block; depends on nothing.
package edett_pkg;

   // Number of slots in the table; handles and cancel indexing rely on a power of two.
   localparam int SLOTS = 16;
   localparam int IDX_W = $clog2(SLOTS);

   // Operation codes.
   localparam logic [2:0] OP_TICK       = 3'd0;
   localparam logic [2:0] OP_SCHED_ONCE = 3'd1;
   localparam logic [2:0] OP_SCHED_REP  = 3'd2;
   localparam logic [2:0] OP_CANCEL_HND = 3'd3;
   localparam logic [2:0] OP_CANCEL_TGT = 3'd4;

   // Status codes.
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_NO_TGT = 2'd2;

   typedef struct packed {
      logic [2:0]  op;
      logic [63:0] now_time;
      logic [63:0] due_time;
      logic [63:0] period;
      logic [7:0]  target_id;
      logic [31:0] message_tag;
      logic [31:0] cancel_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        fired;
      logic [31:0] new_handle;
      logic [7:0]  fire_target;
      logic [31:0] fire_message;
   } rsp_type;

   // One slot of the table.
   typedef struct packed {
      logic [7:0]  target;
      logic [31:0] message;
      logic [63:0] due;
      logic [63:0] period;
      logic        repeats;
      logic [31:0] handle;
   } slot_type;

   // Edit command handed to the head editor during the apply pass.
   typedef struct packed {
      logic             apply;
      logic             fire;
      logic [IDX_W-1:0] fire_idx;
      logic             place;
      logic [IDX_W-1:0] place_idx;
      logic [31:0]      place_handle;
   } edit_type;

endpackage

// ===== rtl/earliest_deadline_event_timer_table_top.sv =====
// Top level of the earliest-deadline event timer table.
// Holds the sequencer, the chain of slot cells and the head editor.
// Depends on edett_pkg, edett_cell and edett_edit.

// The slot records sit in a ring of cells that rotates by one slot per cycle
// during the scan and apply passes. Each item is accepted, then a scan pass
// over the ring finds the earliest valid due time and the lowest free slot,
// an apply pass rotates the ring once more while the head editor changes the
// slot or slots the item touches, and the result is loaded. One item is
// worked at a time; the next item is taken once the result is loaded into the
// output register, and may enter while that result still waits to be taken.
module earliest_deadline_event_timer_table_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  edett_pkg::req_type req_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output edett_pkg::rsp_type rsp_item
);

   typedef enum logic [1:0] {IDLE, SCAN, APPLY, DONE} state_type;

   state_type                  state_ff;
   logic [edett_pkg::IDX_W-1:0] step_ff;
   edett_pkg::req_type         item_ff;
   logic                       found_ff;
   logic [edett_pkg::IDX_W-1:0] best_idx_ff;
   logic [63:0]                best_due_ff;
   logic [7:0]                 best_target_ff;
   logic [31:0]                best_msg_ff;
   logic                       free_found_ff;
   logic [edett_pkg::IDX_W-1:0] free_idx_ff;
   logic [31:0]                counter_ff;
   logic                       rsp_valid_ff;
   edett_pkg::rsp_type         rsp_ff;

   edett_pkg::slot_type        chain [edett_pkg::SLOTS];
   edett_pkg::slot_type        edited;
   edett_pkg::edit_type        cmd;
   edett_pkg::rsp_type         rsp_in;
   logic                       shift;
   logic                       last_step;
   logic                       fire;
   logic                       is_sched;
   logic                       load_rsp;

   assign shift     = (state_ff == SCAN) || (state_ff == APPLY);
   assign last_step = (step_ff == edett_pkg::IDX_W'(edett_pkg::SLOTS - 1));
   assign fire      = found_ff && (best_due_ff < item_ff.now_time);
   assign is_sched  = (item_ff.op == edett_pkg::OP_SCHED_ONCE) ||
                      (item_ff.op == edett_pkg::OP_SCHED_REP);
   assign load_rsp  = (state_ff == DONE) && (!rsp_valid_ff || !rsp_stall);

   // Edit command for the apply pass.
   always_comb begin
      cmd.apply        = (state_ff == APPLY);
      cmd.fire         = fire;
      cmd.fire_idx     = best_idx_ff;
      cmd.place        = free_found_ff;
      cmd.place_idx    = free_idx_ff;
      cmd.place_handle = counter_ff + 32'(free_idx_ff);
   end

   // Ring of cells; the head record goes through the editor to the tail.
   for (genvar g = 0; g < edett_pkg::SLOTS; g++) begin : g_cell
      edett_pkg::slot_type nxt;
      if (g == edett_pkg::SLOTS - 1) begin : g_tail
         assign nxt = edited;
      end else begin : g_mid
         assign nxt = chain[g + 1];
      end
      edett_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift   (shift),
         .rec_in  (nxt),
         .rec_out (chain[g])
      );
   end

   edett_edit u_edit (
      .head (chain[0]),
      .idx  (step_ff),
      .item (item_ff),
      .cmd  (cmd),
      .rec  (edited)
   );

   // Result of the finished item.
   always_comb begin
      rsp_in = '0;
      case (item_ff.op) inside
         edett_pkg::OP_TICK: begin
            if (fire) begin
               rsp_in.fired        = 1'b1;
               rsp_in.fire_target  = best_target_ff;
               rsp_in.fire_message = best_msg_ff;
            end
         end
         edett_pkg::OP_SCHED_ONCE, edett_pkg::OP_SCHED_REP: begin
            if (free_found_ff) begin
               rsp_in.new_handle = cmd.place_handle;
            end else begin
               rsp_in.status = edett_pkg::ST_FULL;
            end
         end
         edett_pkg::OP_CANCEL_TGT: begin
            if (item_ff.target_id == '0) begin
               rsp_in.status = edett_pkg::ST_NO_TGT;
            end
         end
         default: begin
         end
      endcase
   end

   // Sequencer: scan pass, apply pass, then hand the result over.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         step_ff       <= '0;
         counter_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         // The output register fills from a finished item or empties when taken.
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  item_ff       <= req_item;
                  found_ff      <= 1'b0;
                  free_found_ff <= 1'b0;
                  step_ff       <= '0;
                  state_ff      <= SCAN;
               end
            end
            SCAN: begin
               if (chain[0].target != '0 &&
                   (!found_ff || chain[0].due < best_due_ff)) begin
                  found_ff       <= 1'b1;
                  best_idx_ff    <= step_ff;
                  best_due_ff    <= chain[0].due;
                  best_target_ff <= chain[0].target;
                  best_msg_ff    <= chain[0].message;
               end
               if (chain[0].target == '0 && !free_found_ff) begin
                  free_found_ff <= 1'b1;
                  free_idx_ff   <= step_ff;
               end
               step_ff <= step_ff + 1'b1;
               if (last_step) begin
                  state_ff <= APPLY;
               end
            end
            APPLY: begin
               step_ff <= step_ff + 1'b1;
               if (last_step) begin
                  state_ff <= DONE;
               end
            end
            DONE: begin
               // The handle counter moves on once the handle is in the result.
               if (load_rsp) begin
                  rsp_ff   <= rsp_in;
                  state_ff <= IDLE;
                  if (is_sched && free_found_ff) begin
                     counter_ff <= counter_ff + 32'(edett_pkg::SLOTS);
                  end
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // The step counter rests at zero between items.
   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == IDLE) |-> (step_ff == '0))
      else $error("step counter not at zero while idle");

   // Handles keep the slot index in their low bits.
   a_counter_align: assert property (@(posedge clock) disable iff (reset)
      counter_ff[edett_pkg::IDX_W-1:0] == '0)
      else $error("handle counter lost its alignment");

   // A firing always reports ok status.
   a_fire_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.fired) |-> (rsp_ff.status == edett_pkg::ST_OK))
      else $error("fired result with error status");

endmodule

// ===== rtl/edett_cell.sv =====
// One cell of the rotating slot chain.
// Holds a slot record and takes its neighbor's record on every shift cycle.
// Depends on edett_pkg.
module edett_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  edett_pkg::slot_type rec_in,
   output edett_pkg::slot_type rec_out
);

   edett_pkg::slot_type rec_ff;

   // Reset frees the slot and clears its handle and recurrent flag.
   // The payload fields keep whatever they hold until first written.
   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff.target  <= '0;
         rec_ff.repeats <= 1'b0;
         rec_ff.handle  <= '0;
      end else if (shift) begin
         rec_ff <= rec_in;
      end
   end

   assign rec_out = rec_ff;

endmodule

// ===== rtl/edett_edit.sv =====
// Head editor of the slot chain.
// Applies the current item's change to the record leaving the head cell.
// Depends on edett_pkg.
module edett_edit (
   input  edett_pkg::slot_type       head,
   input  logic [edett_pkg::IDX_W-1:0] idx,
   input  edett_pkg::req_type        item,
   input  edett_pkg::edit_type       cmd,
   output edett_pkg::slot_type       rec
);

   always_comb begin
      rec = head;
      if (cmd.apply) begin
         case (item.op) inside
            edett_pkg::OP_TICK: begin
               // Fired slot: rearm a recurrent event, free a one-shot one.
               if (cmd.fire && idx == cmd.fire_idx) begin
                  if (head.repeats) begin
                     rec.due = head.due + head.period;
                  end else begin
                     rec.target = '0;
                  end
               end
            end
            edett_pkg::OP_SCHED_ONCE, edett_pkg::OP_SCHED_REP: begin
               // Fill the lowest free slot.
               if (cmd.place && idx == cmd.place_idx) begin
                  rec.target  = item.target_id;
                  rec.message = item.message_tag;
                  rec.due     = item.due_time;
                  rec.handle  = cmd.place_handle;
                  rec.repeats = (item.op == edett_pkg::OP_SCHED_REP);
                  if (item.op == edett_pkg::OP_SCHED_REP) begin
                     rec.period = item.period;
                  end
               end
            end
            edett_pkg::OP_CANCEL_HND: begin
               // The handle's low bits name the slot.
               if (idx == item.cancel_handle[edett_pkg::IDX_W-1:0] &&
                   head.handle == item.cancel_handle) begin
                  rec.target = '0;
               end
            end
            edett_pkg::OP_CANCEL_TGT: begin
               if (item.target_id != '0 && head.target == item.target_id) begin
                  rec.target = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule
